// ----- hw/rtl/dqf_pkg.sv -----
package dqf_pkg;

  localparam int unsigned LW_W      = 12;
  localparam int unsigned ZT_W      = 15;
  localparam int unsigned CFG_W     = 15;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned SAT_W     = 36;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST     = 12'd2048;
  localparam logic [ZT_W-1:0] ZERO_THRESHOLD_RST = 15'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH     = 1'b0,
    REG_ZERO_THRESHOLD = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IF,
    ST_IF_WAIT,
    ST_DF,
    ST_DF_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic valid;
    logic take;
    logic eof;
  } win_ctl_t;

  function automatic logic [OUT_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(33'sh0_7FFF_FFFF);
    lo = -SAT_W'(33'sh0_8000_0000);
    if (v > hi) begin
      return 32'h7FFF_FFFF;
    end else if (v < lo) begin
      return 32'h8000_0000;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/dqf_line_store.sv -----
module dqf_line_store import dqf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  logic signed [PIXEL_BITS-1:0] old_pixel_i,
  input  logic signed [PIXEL_BITS-1:0] new_pixel_i,
  input  logic                         outside_domain_i,
  input  logic                         end_of_frame_i,
  input  logic [LW_W-1:0]              line_width_i,
  input  logic [ZT_W-1:0]              zero_threshold_i,
  output win_ctl_t                     ctl_o,
  output logic signed [PIXEL_BITS+2:0] gain_o,
  output logic signed [PIXEL_BITS+2:0] hchg_o,
  output logic signed [PIXEL_BITS+2:0] hsum_o,
  output logic signed [PIXEL_BITS+2:0] vsum_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = 2 * PIXEL_BITS + 1;
  localparam int unsigned TW = PIXEL_BITS + 3;

  logic [EW-1:0] mem [MAX_WIDTH];
  logic [EW-1:0] rd_a_q, rd_r_q;

  logic [CW-1:0] col_q, col_d;
  logic          first_q, first_d;

  logic [31:0]   w_eff, c_ext, c_eff;
  logic          last;
  logic [CW-1:0] addr_a, addr_r;

  logic                         v1_q, score_q, eof1_q, pm_q;
  logic signed [PIXEL_BITS-1:0] po_q, pn_q;

  win_ctl_t ctl_q;
  logic signed [TW-1:0] gain_q, hchg_q, hsum_q, vsum_q;

  logic signed [TW-1:0] ao, an, ro, rn, po, pn;
  logic signed [TW-1:0] dxo, dxn, dyo, dyn, dxd;
  logic signed [TW-1:0] adxo, adyo, adyn, adxd, aao, aan;
  logic                 excl, zero;

  always_comb begin
    if (line_width_i < LW_W'(2)) begin
      w_eff = 32'd2;
    end else if (32'(line_width_i) > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = 32'(line_width_i);
    end
    c_ext = 32'(col_q);
    c_eff = (c_ext > w_eff - 32'd1) ? w_eff - 32'd1 : c_ext;
    last  = (c_eff + 32'd1 >= w_eff);
    addr_a = c_eff[CW-1:0];
    addr_r = addr_a + CW'(1);
    if (end_of_frame_i) begin
      col_d   = '0;
      first_d = 1'b1;
    end else if (last) begin
      col_d   = '0;
      first_d = 1'b0;
    end else begin
      col_d   = CW'(c_eff + 32'd1);
      first_d = first_q;
    end
  end

  // line store, read before write on the same entry
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      mem[addr_a] <= {old_pixel_i, new_pixel_i, outside_domain_i};
      rd_a_q      <= mem[addr_a];
      rd_r_q      <= mem[addr_r];
      po_q        <= old_pixel_i;
      pn_q        <= new_pixel_i;
      pm_q        <= outside_domain_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
      v1_q    <= 1'b0;
      score_q <= 1'b0;
      eof1_q  <= 1'b0;
    end else begin
      v1_q <= acc_i;
      if (acc_i) begin
        col_q   <= col_d;
        first_q <= first_d;
        score_q <= !first_q && !last;
        eof1_q  <= end_of_frame_i;
      end
    end
  end

  always_comb begin
    ao = TW'(signed'(rd_a_q[EW-1 -: PIXEL_BITS]));
    an = TW'(signed'(rd_a_q[PIXEL_BITS:1]));
    ro = TW'(signed'(rd_r_q[EW-1 -: PIXEL_BITS]));
    rn = TW'(signed'(rd_r_q[PIXEL_BITS:1]));
    po = TW'(po_q);
    pn = TW'(pn_q);
    dxo = ro - ao;
    dxn = rn - an;
    dyo = po - ao;
    dyn = pn - an;
    dxd = dxo - dxn;
    adxo = dxo[TW-1] ? -dxo : dxo;
    adyo = dyo[TW-1] ? -dyo : dyo;
    adyn = dyn[TW-1] ? -dyn : dyn;
    adxd = dxd[TW-1] ? -dxd : dxd;
    aao  = ao[TW-1] ? -ao : ao;
    aan  = an[TW-1] ? -an : an;
    excl = rd_a_q[0] || rd_r_q[0] || pm_q;
    zero = (32'(aao) < 32'(zero_threshold_i)) && (32'(aan) < 32'(zero_threshold_i));
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      gain_q <= adyo - adyn;
      hchg_q <= adxd;
      hsum_q <= adxo;
      vsum_q <= adyo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.valid <= v1_q;
      ctl_q.take  <= v1_q && score_q && !excl && !zero;
      ctl_q.eof   <= v1_q && eof1_q;
    end
  end

  assign ctl_o  = ctl_q;
  assign gain_o = gain_q;
  assign hchg_o = hchg_q;
  assign hsum_o = hsum_q;
  assign vsum_o = vsum_q;

endmodule

// ----- hw/rtl/dqf_divider.sv -----
module dqf_divider import dqf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] num_i,
  input  logic [SUM_W-1:0] den_i,
  output logic             done_o,
  output logic             neg_o,
  output logic [OUT_W:0]   quot_o
);

  localparam int unsigned IS = OUT_W - FRAC_BITS;

  logic             busy_q, done_q, neg_q, ovf_q;
  logic [4:0]       cnt_q;
  logic [SUM_W-1:0] rem_q, den_q;
  logic [OUT_W-1:0] low_q, q_q;

  logic [SUM_W-1:0] mag, hi;
  logic [SUM_W:0]   t;
  logic             ge;

  always_comb begin
    mag = num_i[SUM_W-1] ? (~num_i + SUM_W'(1)) : num_i;
    hi  = mag >> IS;
    t   = {rem_q, low_q[OUT_W-1]};
    ge  = (t >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= hi;
      den_q <= den_i;
      low_q <= mag[OUT_W-1:0] << FRAC_BITS;
      neg_q <= num_i[SUM_W-1];
      ovf_q <= (hi >= den_i);
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? SUM_W'(t - {1'b0, den_q}) : t[SUM_W-1:0];
      low_q <= low_q << 1;
      q_q   <= {q_q[OUT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !(hi >= den_i);
        done_q <= (hi >= den_i);
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign neg_o  = neg_q;
  assign quot_o = ovf_q ? {1'b1, {OUT_W{1'b0}}} : {1'b0, q_q};

endmodule

// ----- hw/rtl/destripe_quality_factors.sv -----
// destripe quality factors
//
// input channel: one word per pixel in raster order, original and destriped
// pixel, domain-exclusion bit and end-of-frame mark. handshake is valid and
// stall; a word is taken on a clock edge with valid high and stall low.
// output channel: one word per frame with the improvement factor, the
// distortion factor (both signed q15.16, saturated) and the window count.
// configuration: write enable, register index, data; write only when idle.
//
// throughput: one pixel per cycle inside a frame; the line store is one
// memory read at two columns and written at one column in the same cycle.
// after the end-of-frame pixel, input stalls while two serial divisions run
// (a division is skipped when its divisor is not positive and ends early
// when the quotient clamps), then the result word is offered. a stalled
// result holds and the input stays stalled until it is taken. reset clears
// sums, count, column and row state; the line store holds garbage until
// written, no clearing pass is needed.
module destripe_quality_factors import dqf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_W-1:0]             cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [PIXEL_BITS-1:0] old_pixel_i,
  input  logic signed [PIXEL_BITS-1:0] new_pixel_i,
  input  logic                         outside_domain_i,
  input  logic                         end_of_frame_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [OUT_W-1:0]      improvement_factor_o,
  output logic signed [OUT_W-1:0]      distortion_factor_o,
  output logic [OUT_W-1:0]             window_count_o
);

  localparam int unsigned TW = PIXEL_BITS + 3;

  logic [LW_W-1:0] line_width_q;
  logic [ZT_W-1:0] zero_threshold_q;

  state_e state_q, state_d;

  logic             acc;
  win_ctl_t         ctl;
  logic signed [TW-1:0] gain, hchg, hsum, vsum;

  logic [SUM_W-1:0] gy_q, cx_q, sx_q, sy_q;
  logic [SUM_W-1:0] gy_d, cx_d, sx_d, sy_d;
  logic [OUT_W-1:0] cnt_q, cnt_d;

  logic [OUT_W-1:0] if_q, df_q, wc_q;

  logic             div_start, div_done, div_neg;
  logic [OUT_W:0]   div_quot;
  logic [SUM_W-1:0] div_num, div_den;
  logic signed [SAT_W-1:0] sq, df_val;
  logic             sy_pos, sx_pos;

  logic lstore_eof1;
  logic acc_eof_q;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || ctl.eof || lstore_eof1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_eof_q <= 1'b0;
    end else begin
      acc_eof_q <= acc && end_of_frame_i;
    end
  end
  assign lstore_eof1 = acc_eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q     <= LINE_WIDTH_RST;
      zero_threshold_q <= ZERO_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LINE_WIDTH:     line_width_q     <= cfg_data_i[LW_W-1:0];
        REG_ZERO_THRESHOLD: zero_threshold_q <= cfg_data_i[ZT_W-1:0];
        default: ;
      endcase
    end
  end

  dqf_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_store (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (acc),
    .old_pixel_i      (old_pixel_i),
    .new_pixel_i      (new_pixel_i),
    .outside_domain_i (outside_domain_i),
    .end_of_frame_i   (end_of_frame_i),
    .line_width_i     (line_width_q),
    .zero_threshold_i (zero_threshold_q),
    .ctl_o            (ctl),
    .gain_o           (gain),
    .hchg_o           (hchg),
    .hsum_o           (hsum),
    .vsum_o           (vsum)
  );

  dqf_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .neg_o   (div_neg),
    .quot_o  (div_quot)
  );

  always_comb begin
    gy_d  = gy_q + SUM_W'(gain);
    cx_d  = cx_q + SUM_W'(hchg);
    sx_d  = sx_q + SUM_W'(hsum);
    sy_d  = sy_q + SUM_W'(vsum);
    cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + OUT_W'(1);
    sy_pos = !sy_q[SUM_W-1] && (sy_q != '0);
    sx_pos = !sx_q[SUM_W-1] && (sx_q != '0);
    sq     = div_neg ? -SAT_W'(div_quot) : SAT_W'(div_quot);
    df_val = (SAT_W'(1) <<< FRAC_BITS) - sq;
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = gy_q;
    div_den   = sy_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctl.valid && ctl.eof) begin
          state_d = ST_IF;
        end
      end
      ST_IF: begin
        div_start = sy_pos;
        state_d   = sy_pos ? ST_IF_WAIT : ST_DF;
      end
      ST_IF_WAIT: begin
        if (div_done) begin
          state_d = ST_DF;
        end
      end
      ST_DF: begin
        div_num   = cx_q;
        div_den   = sx_q;
        div_start = sx_pos;
        state_d   = sx_pos ? ST_DF_WAIT : ST_OUT;
      end
      ST_DF_WAIT: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gy_q    <= '0;
      cx_q    <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && ctl.valid && ctl.take) begin
        gy_q  <= gy_d;
        cx_q  <= cx_d;
        sx_q  <= sx_d;
        sy_q  <= sy_d;
        cnt_q <= cnt_d;
      end
      // frame state clears once both quotients are in
      if (state_d == ST_OUT && state_q != ST_OUT) begin
        gy_q  <= '0;
        cx_q  <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IF: begin
        if_q <= '0;
      end
      ST_IF_WAIT: begin
        if (div_done) begin
          if_q <= sat32(sq);
        end
      end
      ST_DF: begin
        df_q <= 32'(1) << FRAC_BITS;
        wc_q <= cnt_q;
      end
      ST_DF_WAIT: begin
        if (div_done) begin
          df_q <= sat32(df_val);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o          = (state_q == ST_OUT);
  assign improvement_factor_o = if_q;
  assign distortion_factor_o  = df_q;
  assign window_count_o       = wc_q;

endmodule

// ----- hw/rtl/dqf_checker.sv -----
module dqf_checker import dqf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             end_of_frame_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [OUT_W-1:0] improvement_factor_o,
  input logic [OUT_W-1:0] distortion_factor_o,
  input logic [OUT_W-1:0] window_count_o
);

  // input closes after the last word of a frame
  a_eof_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_frame_i |=> in_stall_o)
    else $error("input not stalled after end of frame");

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  a_out_from_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without frame end");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(improvement_factor_o)
      && $stable(distortion_factor_o) && $stable(window_count_o))
    else $error("stalled result word changed");

endmodule

bind destripe_quality_factors dqf_checker u_dqf_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .end_of_frame_i       (end_of_frame_i),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .improvement_factor_o (improvement_factor_o),
  .distortion_factor_o  (distortion_factor_o),
  .window_count_o       (window_count_o)
);

// ----- bench/destripe_quality_factors_tb.sv -----
module destripe_quality_factors_tb;
  import dqf_pkg::*;

  typedef struct packed {
    logic [31:0] imp;
    logic [31:0] dfac;
    logic [31:0] cnt;
  } score_t;

  typedef struct {
    logic signed [15:0] po;
    logic signed [15:0] pn;
    bit                 m;
    bit                 eof;
    bit                 typed;
    score_t             val;
  } dir_row_t;

  localparam score_t NO_WINDOWS = '{imp: 32'd0, dfac: 32'd65536, cnt: 32'd0};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  cfg_reg_e           cfg_index_i = REG_LINE_WIDTH;
  logic [CFG_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] old_pixel_i = '0;
  logic signed [15:0] new_pixel_i = '0;
  logic               outside_domain_i = 1'b0;
  logic               end_of_frame_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] improvement_factor_o;
  logic signed [31:0] distortion_factor_o;
  logic [31:0]        window_count_o;

  destripe_quality_factors uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [11:0] width_q;
  logic [14:0] thresh_q;
  int          old_row[2048];
  int          new_row[2048];
  bit          mask_row[2048];
  int unsigned col_q;
  bit          first_row_q;
  longint      gain_sum, hchg_sum, hsum, vsum;
  int unsigned wins_q;

  score_t frame_scores[$];
  int     errors = 0;
  int     pixels_sent = 0;
  int     frames_sent = 0;
  int     words_seen = 0;
  bit     gap_on = 1'b1;
  int     stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int mag(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_q;
    if (w < 2) w = 2;
    if (w > 2048) w = 2048;
    return w;
  endfunction

  // n / d in q16, truncated, magnitude clamped at 2^32
  function automatic longint ratio_q16(input longint n, input longint d);
    logic [63:0]  un, ud, ip;
    logic [127:0] q;
    un = (n < 0) ? -n : n;
    ud = d;
    ip = un / ud;
    if (ip >= 64'd65536) q = 128'h1_0000_0000;
    else q = {64'd0, un} * 128'd65536 / {64'd0, ud};
    return (n < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void clear_frame_state();
    col_q = 0;
    first_row_q = 1'b1;
    gain_sum = 0;
    hchg_sum = 0;
    hsum = 0;
    vsum = 0;
    wins_q = 0;
  endfunction

  function automatic bit score_pixel(input logic signed [15:0] po, pn, input bit m, eof,
                                     output score_t s);
    int unsigned w, c;
    int ao, an, ro, rn, dxo, dxn, dyo, dyn;
    bit last;
    longint nif, ndf;
    w = eff_width();
    c = col_q;
    if (c > w - 1) c = w - 1;
    last = (c + 1 >= w);
    if (!first_row_q && !last) begin
      ao = old_row[c];
      an = new_row[c];
      ro = old_row[c+1];
      rn = new_row[c+1];
      if (!(mask_row[c] || mask_row[c+1] || m) &&
          !(mag(ao) < int'(thresh_q) && mag(an) < int'(thresh_q))) begin
        dxo = ro - ao;
        dxn = rn - an;
        dyo = int'(po) - ao;
        dyn = int'(pn) - an;
        gain_sum += longint'(mag(dyo) - mag(dyn));
        hchg_sum += longint'(mag(dxo - dxn));
        hsum += longint'(mag(dxo));
        vsum += longint'(mag(dyo));
        if (wins_q != 32'hFFFF_FFFF) wins_q++;
      end
    end
    old_row[c] = po;
    new_row[c] = pn;
    mask_row[c] = m;
    if (last) begin
      col_q = 0;
      first_row_q = 1'b0;
    end else begin
      col_q = c + 1;
    end
    s = '0;
    if (!eof) return 1'b0;
    nif = 0;
    ndf = 65536;
    if (vsum > 0) nif = ratio_q16(gain_sum, vsum);
    if (hsum > 0) ndf = 65536 - ratio_q16(hchg_sum, hsum);
    s.imp = clip32(nif);
    s.dfac = clip32(ndf);
    s.cnt = wins_q;
    clear_frame_state();
    return 1'b1;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [14:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LINE_WIDTH) width_q = v[11:0];
    else thresh_q = v;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_scores.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic signed [15:0] po, pn, input bit m, eof,
                            input bit typed, input score_t typed_val);
    int gap;
    score_t s;
    gap = gap_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    old_pixel_i <= po;
    new_pixel_i <= pn;
    outside_domain_i <= m;
    end_of_frame_i <= eof;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixels_sent++;
    if (score_pixel(po, pn, m, eof, s)) begin
      frame_scores.push_back(typed ? typed_val : s);
      frames_sent++;
    end
  endtask

  task automatic run_frame(input int rows, input bit cut);
    int n, mode, base, i;
    logic signed [15:0] po, pn;
    bit m;
    n = rows * eff_width();
    if (cut) n = $urandom_range(1, n);
    mode = $urandom_range(0, 2);
    base = $urandom_range(0, 65535) - 32768;
    gap_on = ($urandom_range(0, 3) != 0);
    for (i = 0; i < n; i++) begin
      case (mode)
        0: begin
          po = 16'($urandom);
          pn = 16'($urandom);
        end
        1: begin
          po = 16'(base + $urandom_range(0, 60) - 30);
          pn = 16'(base + $urandom_range(0, 60) - 30);
        end
        default: begin
          po = 16'(base + $urandom_range(0, 1));
          pn = 16'($urandom);
        end
      endcase
      m = ($urandom_range(0, 11) == 0);
      send_pixel(po, pn, m, i == n - 1, 1'b0, '0);
    end
  endtask

  dir_row_t dir_rows[] = '{
    '{16'sd5, 16'sd5, 0, 1, 1, NO_WINDOWS},
    // saturating improvement and a window with no vertical change
    '{16'sd100, 16'sd100, 0, 0, 0, '0},
    '{16'sd100, 16'sd100, 0, 0, 0, '0},
    '{16'sd101, 16'sd100, 0, 0, 0, '0},
    '{16'sd100, 16'sd100, 0, 0, 0, '0},
    '{16'sd101, -16'sd32668, 0, 0, 0, '0},
    '{16'sd101, -16'sd32668, 0, 0, 0, '0},
    '{16'sd101, 16'sd32767, 0, 0, 0, '0},
    '{16'sd0, 16'sd0, 0, 1, 0, '0},
    // pixel extremes
    '{-16'sd32768, 16'sd32767, 0, 0, 0, '0},
    '{16'sd32767, -16'sd32768, 0, 0, 0, '0},
    '{16'sd0, 16'sd0, 0, 0, 0, '0},
    '{-16'sd1, -16'sd1, 0, 1, 0, '0},
    // excluded lower pixel
    '{16'sd7, 16'sd7, 0, 0, 0, '0},
    '{16'sd7, 16'sd7, 0, 0, 0, '0},
    '{16'sd8, 16'sd9, 1, 0, 0, '0},
    '{16'sd1, 16'sd1, 0, 1, 1, NO_WINDOWS},
    // origin below zero threshold
    '{16'sd0, 16'sd0, 0, 0, 0, '0},
    '{16'sd5, 16'sd5, 0, 0, 0, '0},
    '{16'sd9, 16'sd9, 0, 0, 0, '0},
    '{16'sd9, 16'sd9, 0, 1, 1, NO_WINDOWS},
    // saturating distortion
    '{16'sd0, 16'sd32767, 0, 0, 0, '0},
    '{16'sd1, -16'sd32768, 0, 0, 0, '0},
    '{16'sd0, 16'sd32767, 0, 0, 0, '0},
    '{16'sd0, 16'sd0, 0, 1, 0, '0}
  };

  // result side: random stall and compare
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        words_seen++;
        if (frame_scores.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word: %h %h %h",
                                     improvement_factor_o, distortion_factor_o, window_count_o);
        end else begin
          score_t e;
          e = frame_scores.pop_front();
          if (e.imp !== improvement_factor_o || e.dfac !== distortion_factor_o ||
              e.cnt !== window_count_o) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp imp %h dist %h cnt %0d, got imp %h dist %h cnt %0d",
                       e.imp, e.dfac, e.cnt, improvement_factor_o, distortion_factor_o,
                       window_count_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        out_stall_i <= (stall_left > 0);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int k, r, j;
    width_q = LINE_WIDTH_RST;
    thresh_q = ZERO_THRESHOLD_RST;
    clear_frame_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_LINE_WIDTH, 15'd1);
    write_reg(REG_ZERO_THRESHOLD, 15'd1);
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].po, dir_rows[i].pn, dir_rows[i].m, dir_rows[i].eof,
                 dir_rows[i].typed, dir_rows[i].val);
    wait_idle();

    k = 0;
    while (pixels_sent < 800) begin
      if (k % 3 == 0) begin
        wait_idle();
        r = $urandom_range(0, 9);
        case (r)
          0: write_reg(REG_LINE_WIDTH, 15'd0);
          1: write_reg(REG_LINE_WIDTH, 15'd2);
          2: write_reg(REG_LINE_WIDTH, 15'($urandom_range(17, 40)));
          default: write_reg(REG_LINE_WIDTH, 15'($urandom_range(1, 12)));
        endcase
        r = $urandom_range(0, 9);
        case (r)
          0: write_reg(REG_ZERO_THRESHOLD, 15'd0);
          1: write_reg(REG_ZERO_THRESHOLD, 15'h7FFF);
          2: write_reg(REG_ZERO_THRESHOLD, 15'($urandom_range(0, 32767)));
          default: write_reg(REG_ZERO_THRESHOLD, 15'($urandom_range(1, 40)));
        endcase
      end
      run_frame($urandom_range(1, 6), $urandom_range(0, 5) == 0);
      k++;
    end

    // short frames at a width above the maximum, then exactly at it
    wait_idle();
    write_reg(REG_LINE_WIDTH, 15'd4095);
    write_reg(REG_ZERO_THRESHOLD, 15'd1);
    for (j = 0; j < 30; j++)
      send_pixel(16'($urandom), 16'($urandom), $urandom_range(0, 11) == 0, j == 29,
                 1'b0, '0);
    wait_idle();
    write_reg(REG_LINE_WIDTH, 15'd2048);
    for (j = 0; j < 30; j++)
      send_pixel(16'($urandom), 16'($urandom), $urandom_range(0, 11) == 0, j == 29,
                 1'b0, '0);

    wait_idle();
    $display("%0d pixels in %0d frames sent, %0d result words checked",
             pixels_sent, frames_sent, words_seen);
    if (errors == 0 && frame_scores.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, frame_scores.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
